// ===== hdl/nwa_pkg.sv =====
// Shared constants and control types of the grammar word acceptor.
`timescale 1ns / 1ps

package nwa_pkg;

	localparam int DEF_NUM_NONTERMINALS = 26;
	localparam int DEF_NUM_SYMBOLS      = 26;
	localparam int FIELD_W              = 5;

	localparam logic FUNC_RULE   = 1'b0;
	localparam logic FUNC_SYMBOL = 1'b1;

	// Controller to datapath.
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic rule_wr;
		logic scan_step;
		logic finish;
	} nwa_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic item_symbol;
		logic item_rule_ok;
		logic scan_last;
		logic word_last;
		logic out_busy;
	} nwa_stat_t;

endpackage

// ===== hdl/nwa_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps

interface nwa_in_if
	import nwa_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               func;
	logic [FIELD_W-1:0] rule_from;
	logic [FIELD_W-1:0] symbol;
	logic [FIELD_W-1:0] rule_to;
	logic               last_symbol;

	modport source (output valid, func, rule_from, symbol, rule_to, last_symbol,
		input ready);
	modport sink (input valid, func, rule_from, symbol, rule_to, last_symbol,
		output ready);
endinterface

interface nwa_out_if;
	logic valid;
	logic ready;
	logic accepted;

	modport source (output valid, accepted, input ready);
	modport sink (input valid, accepted, output ready);
endinterface

// ===== hdl/nwa_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module nwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/nwa_ctrl.sv =====
// Sequencer of the word acceptor: clearing pass, rule update and state-set scan.
`timescale 1ns / 1ps

module nwa_ctrl
	import nwa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  nwa_stat_t stat,
	output nwa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RULE_RD,
		ST_RULE_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept     = (state_q == ST_IDLE) && item_valid;
	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.capture   = accept;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (stat.item_symbol) begin
						state_d = ST_SCAN;
					end else if (stat.item_rule_ok) begin
						state_d = ST_RULE_RD;
					end
				end
			end
			ST_RULE_RD: begin
				state_d = ST_RULE_WR;
			end
			ST_RULE_WR: begin
				cmd.rule_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!(stat.word_last && stat.out_busy)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item_ready)
		else $error("item taken during clearing pass");
	a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stat.scan_last) |=> (state_q == ST_DRAIN))
		else $error("scan did not hand over to drain");
	a_rule_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rule_wr |-> ($past(state_q) == ST_RULE_RD))
		else $error("rule write without preceding read");
`endif

endmodule

// ===== hdl/nwa_dp.sv =====
// Datapath of the word acceptor: rule table, active set, scan counter and result register.
`timescale 1ns / 1ps

module nwa_dp
	import nwa_pkg::*;
#(
	parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
	parameter int NUM_SYMBOLS      = DEF_NUM_SYMBOLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nwa_cmd_t           cmd,
	output nwa_stat_t          stat,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data,
	input  logic               func,
	input  logic [FIELD_W-1:0] rule_from,
	input  logic [FIELD_W-1:0] symbol,
	input  logic [FIELD_W-1:0] rule_to,
	input  logic               last_symbol,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               result_accepted
);

	localparam int DEPTH = NUM_NONTERMINALS * NUM_SYMBOLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = (NUM_NONTERMINALS > 1) ? $clog2(NUM_NONTERMINALS) : 1;
	localparam int RW    = NUM_NONTERMINALS + 1;

	logic [FIELD_W-1:0] start_q;
	logic [RW-1:0]      active_q;
	logic [RW-1:0]      next_q;
	logic               word_open_q;
	logic [AW-1:0]      addr_q;
	logic [NW-1:0]      cnt_q;
	logic               sym_ok_q;
	logic               last_q;
	logic [FIELD_W-1:0] to_q;
	logic               acc_vld_s1;
	logic               out_valid_q;
	logic               accepted_q;

	logic [RW-1:0] start_set;
	logic [RW-1:0] row_rd;
	logic [RW-1:0] row_wr;
	logic [RW-1:0] to_mask;
	logic          sym_ok_in;
	logic          rule_ok_in;
	logic [AW-1:0] rule_addr;
	logic          ram_we;

	assign start_set  = (int'(start_q) < NUM_NONTERMINALS) ? (RW'(1) << start_q) : '0;
	assign to_mask    = RW'(1) << to_q;
	assign sym_ok_in  = int'(symbol) < NUM_SYMBOLS;
	assign rule_ok_in = (int'(rule_from) < NUM_NONTERMINALS) && sym_ok_in
		&& (int'(rule_to) <= NUM_NONTERMINALS);
	assign rule_addr  = rule_ok_in ? AW'(int'(rule_from) * NUM_SYMBOLS + int'(symbol)) : '0;

	assign ram_we = cmd.clr_step || cmd.rule_wr;
	assign row_wr = cmd.clr_step ? '0 : (row_rd | to_mask);

	nwa_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_rules (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(row_wr),
		.raddr(addr_q),
		.rdata(row_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			word_open_q <= 1'b0;
			addr_q      <= '0;
			cnt_q       <= '0;
			acc_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_data;
			end
			acc_vld_s1 <= cmd.scan_step && sym_ok_q && active_q[cnt_q];
			if (cmd.clr_step) begin
				addr_q <= addr_q + 1'b1;
			end else if (cmd.capture) begin
				cnt_q <= '0;
				if (func == FUNC_RULE) begin
					addr_q <= rule_addr;
				end else begin
					addr_q <= sym_ok_in ? AW'(symbol) : '0;
				end
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + 1'b1;
				if (sym_ok_q) begin
					addr_q <= addr_q + AW'(NUM_SYMBOLS);
				end
			end
			if (cmd.finish) begin
				word_open_q <= !last_q;
			end
			if (cmd.finish && last_q) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			last_q   <= last_symbol;
			to_q     <= rule_to;
			sym_ok_q <= sym_ok_in;
			next_q   <= '0;
			if (func == FUNC_SYMBOL && !word_open_q) begin
				active_q <= start_set;
			end
		end else if (acc_vld_s1) begin
			next_q <= next_q | row_rd;
		end
		if (cmd.finish && !last_q) begin
			active_q <= next_q;
		end
		if (cmd.finish && last_q) begin
			accepted_q <= next_q[NUM_NONTERMINALS];
		end
	end

	assign stat.clr_last     = (int'(addr_q) == DEPTH - 1);
	assign stat.item_symbol  = (func == FUNC_SYMBOL);
	assign stat.item_rule_ok = rule_ok_in;
	assign stat.scan_last    = (int'(cnt_q) == NUM_NONTERMINALS - 1);
	assign stat.word_last    = last_q;
	assign stat.out_busy     = out_valid_q && !result_ready;

	assign result_valid    = out_valid_q;
	assign result_accepted = accepted_q;

`ifndef ASSERT_OFF
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && last_q) |-> !(out_valid_q && !result_ready))
		else $error("pending result overwritten");
	a_acc_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		acc_vld_s1 |-> $past(cmd.scan_step))
		else $error("accumulate without a table read");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (int'(cnt_q) < NUM_NONTERMINALS))
		else $error("scan counter past last nonterminal");
	a_word_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && last_q) |=> !word_open_q)
		else $error("word still open after its last symbol");
`endif

endmodule

// ===== hdl/nfa_word_acceptor.sv =====
// Top level of the right-linear grammar word acceptor.
//
//  channel  | kind            | carries
//  ---------+-----------------+----------------------------------------------
//  item     | valid/ready in  | func, rule_from, symbol, rule_to, last_symbol
//  result   | valid/ready out | accepted
//  cfg      | write enable    | start_state (cfg_data)
//
// A rule word passes through capture, table read and table write; an out-of-range
// rule is dropped at capture. A symbol word is captured, then the scan reads one
// table row per nonterminal through the single read port of the rule table, then
// drains the read register and commits the set.
// After reset a clearing pass writes zero to all NUM_NONTERMINALS * NUM_SYMBOLS
// rows with item.ready held low.
// A finished result sits in an output register; the next word is taken while it
// waits, and only a second word-ending symbol stalls until result.ready.
`timescale 1ns / 1ps

module nfa_word_acceptor
	import nwa_pkg::*;
#(
	parameter int NUM_NONTERMINALS = DEF_NUM_NONTERMINALS,
	parameter int NUM_SYMBOLS      = DEF_NUM_SYMBOLS
) (
	input  logic               clk,
	input  logic               arst_n,
	nwa_in_if.sink             item,
	nwa_out_if.source          result,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data
);

	// Command and status between sequencer and datapath.
	nwa_cmd_t  cmd;
	nwa_stat_t stat;

	// Sequencer: hold off items during the clearing pass, step the scan.
	nwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: rule table, active state set and the result register.
	nwa_dp #(
		.NUM_NONTERMINALS(NUM_NONTERMINALS),
		.NUM_SYMBOLS     (NUM_SYMBOLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.func           (item.func),
		.rule_from      (item.rule_from),
		.symbol         (item.symbol),
		.rule_to        (item.rule_to),
		.last_symbol    (item.last_symbol),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.result_accepted(result.accepted)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the grammar word acceptor: directed table, then random sentences.
`timescale 1ns / 1ps

module tb_top
	import nwa_pkg::*;
	;

	localparam int NT = DEF_NUM_NONTERMINALS;
	localparam int NS = DEF_NUM_SYMBOLS;

	// Field values used by the directed table.
	localparam logic [FIELD_W-1:0] NT_A          = 5'd0;
	localparam logic [FIELD_W-1:0] NT_B          = 5'd1;
	localparam logic [FIELD_W-1:0] NT_Z          = 5'd25;
	localparam logic [FIELD_W-1:0] LET_A         = 5'd0;
	localparam logic [FIELD_W-1:0] LET_B         = 5'd1;
	localparam logic [FIELD_W-1:0] LET_Z         = 5'd25;
	localparam logic [FIELD_W-1:0] END_MARK      = 5'd26;
	localparam logic [FIELD_W-1:0] FIRST_BAD_SYM = 5'd26;
	localparam logic [FIELD_W-1:0] FIRST_BAD_TO  = 5'd27;
	localparam logic [FIELD_W-1:0] FIELD_MAX     = 5'd31;
	localparam logic [FIELD_W-1:0] UNUSED        = 5'd0;

	// Scan of a symbol plus drain and commit, with some slack.
	localparam int DRAIN_CYCLES   = NT + 3 + 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1000;

	typedef struct packed {
		logic               func;
		logic [FIELD_W-1:0] rule_from;
		logic [FIELD_W-1:0] symbol;
		logic [FIELD_W-1:0] rule_to;
		logic               last_symbol;
	} item_word_t;

	typedef enum logic {ROW_ITEM, ROW_START} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               func;
		logic [FIELD_W-1:0] rule_from;
		logic [FIELD_W-1:0] symbol;
		logic [FIELD_W-1:0] rule_to;
		logic               last_symbol;
		logic [FIELD_W-1:0] start_val;
		logic               typed;   // verdict below is fixed by hand
		logic               verdict;
	} dir_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	localparam int DIR_ROWS = 26;

	// kind, func, from, symbol, to, last, start, typed, verdict
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// empty table straight after reset: nothing derivable
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_A, UNUSED, 1'b1, UNUSED, 1'b1, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_A, LET_A, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_A, UNUSED, 1'b1, UNUSED, 1'b1, 1'b1},
		// same rule again must leave the table as it was
		'{ROW_ITEM, FUNC_RULE, NT_A, LET_A, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_A, UNUSED, 1'b1, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_A, LET_Z, NT_Z, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_Z, LET_Z, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b1, UNUSED, 1'b0, 1'b0},
		// end marker reached early dies on the next symbol
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_A, UNUSED, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_A, UNUSED, 1'b1, UNUSED, 1'b0, 1'b0},
		// rules with a field out of range are dropped
		'{ROW_ITEM, FUNC_RULE, FIELD_MAX, LET_A, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_A, FIELD_MAX, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_A, LET_B, FIELD_MAX, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_A, LET_B, FIRST_BAD_TO, 1'b0, UNUSED, 1'b0, 1'b0},
		// last flag on a rule word means nothing
		'{ROW_ITEM, FUNC_RULE, NT_B, LET_A, END_MARK, 1'b1, UNUSED, 1'b0, 1'b0},
		// symbol out of range empties the set
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, FIELD_MAX, UNUSED, 1'b1, UNUSED, 1'b1, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, FIRST_BAD_SYM, UNUSED, 1'b1, UNUSED, 1'b1, 1'b0},
		// rule added in the middle of a sentence applies to what follows
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_RULE, NT_Z, LET_B, END_MARK, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_B, UNUSED, 1'b1, UNUSED, 1'b0, 1'b0},
		// start changed in the middle of a sentence: the open one keeps its set
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b0, UNUSED, 1'b0, 1'b0},
		'{ROW_START, FUNC_RULE, UNUSED, UNUSED, UNUSED, 1'b0, FIELD_MAX, 1'b0, 1'b0},
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b1, UNUSED, 1'b0, 1'b0},
		// start out of range: every sentence rejected
		'{ROW_ITEM, FUNC_SYMBOL, UNUSED, LET_Z, UNUSED, 1'b1, UNUSED, 1'b1, 1'b0},
		'{ROW_START, FUNC_RULE, UNUSED, UNUSED, UNUSED, 1'b0, NT_Z, 1'b0, 1'b0}
	};

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [FIELD_W-1:0] cfg_data = '0;

	nwa_in_if  item_if ();
	nwa_out_if result_if ();

	nfa_word_acceptor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Own copy of the automaton: rule rows, live state set, start register.
	bit [NT:0]          nfa_rows [NT][NS];
	bit [NT:0]          live_set      = {{NT{1'b0}}, 1'b1};
	bit                 sentence_open = 1'b0;
	bit [FIELD_W-1:0]   start_reg     = '0;
	bit                 verdict_q [$];   // acceptance verdicts still owed by the block

	int          errors        = 0;
	int          stall_cycles  = 0;
	bit          hold_off_req  = 1'b0;
	bit          gapless       = 1'b0;
	int unsigned burst_left    = 0;
	int          nt_base       = 0;
	int          sym_base      = 0;

	function automatic bit [NT:0] start_mask();
		bit [NT:0] m;
		m = '0;
		if (start_reg < NT)
			m[start_reg] = 1'b1;
		return m;
	endfunction

	// Advance the automaton by one accepted word; queue a verdict at sentence end.
	function automatic void step_grammar(input item_word_t w, input bit typed,
			input bit verdict);
		bit [NT:0] nxt;
		int        n;
		if (w.func == FUNC_RULE) begin
			if (w.rule_from < NT && w.symbol < NS && w.rule_to <= NT)
				nfa_rows[w.rule_from][w.symbol][w.rule_to] = 1'b1;
			return;
		end
		if (!sentence_open)
			live_set = start_mask();
		nxt = '0;
		if (w.symbol < NS) begin
			for (n = 0; n < NT; n++)
				if (live_set[n])
					nxt |= nfa_rows[n][w.symbol];
		end
		live_set = nxt;
		if (w.last_symbol) begin
			verdict_q = {verdict_q, (typed ? verdict : live_set[NT])};
			sentence_open = 1'b0;
			live_set = start_mask();
		end else begin
			sentence_open = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input bit exp_v, input logic got_v);
		$display("[%0t] mismatch: %s (expected %0b, got %0b)", $time, what, exp_v, got_v);
		errors++;
	endtask

	// Offer one word; enter and leave at a falling edge. Valid stays high on return so
	// that back-to-back words never see it dropped.
	task automatic offer(input item_word_t w, input bit typed, input bit verdict);
		int unsigned gap;
		if (burst_left == 0) begin
			if (!gapless) begin
				gap = $urandom_range(1, 12);
				item_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		item_if.func        = w.func;
		item_if.rule_from   = w.rule_from;
		item_if.symbol      = w.symbol;
		item_if.rule_to     = w.rule_to;
		item_if.last_symbol = w.last_symbol;
		item_if.valid       = 1'b1;
		do @(posedge clk); while (!item_if.ready);
		step_grammar(w, typed, verdict);
		@(negedge clk);
	endtask

	// Hold the sender until every verdict is in, then let a late scan finish.
	task automatic wait_drain();
		item_if.valid = 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_start(input logic [FIELD_W-1:0] v);
		cfg_we   = 1'b1;
		cfg_data = v;
		@(posedge clk);
		start_reg = v;
		if (!sentence_open)
			live_set = start_mask();
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Nonterminal from the phase pool; the start state is one of the candidates.
	function automatic logic [FIELD_W-1:0] pick_nt();
		int k;
		k = $urandom_range(0, 4);
		if (k == 4 && start_reg < NT)
			return start_reg;
		return FIELD_W'((nt_base + k) % NT);
	endfunction

	function automatic logic [FIELD_W-1:0] pick_sym();
		return FIELD_W'((sym_base + $urandom_range(0, 2)) % NS);
	endfunction

	// Receiver: stall pattern changes every so often; a hold-off request forces ready
	// low for a long counted stretch. Decide at the rising edge, drive at the falling one.
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned span;
		int unsigned hold_left;
		logic        nxt;
		result_if.ready = 1'b0;
		mode = RX_FREE;
		span = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(20, 120);
			end
			span--;
			case (mode)
				RX_FREE:   nxt = 1'b1;
				RX_HALF:   nxt = 1'($urandom_range(0, 1));
				RX_SPARSE: nxt = ($urandom_range(0, 3) == 0);
				default:   nxt = ~result_if.ready;
			endcase
			if (hold_left != 0) begin
				hold_left--;
				nxt = 1'b0;
			end
			@(negedge clk);
			result_if.ready = nxt;
		end
	end

	// Compare each verdict the block hands over with the oldest one owed.
	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			if (verdict_q.size() == 0)
				report_mismatch("verdict with none outstanding", 1'b0, result_if.accepted);
			else if (result_if.accepted !== verdict_q[0]) begin
				report_mismatch("accepted", verdict_q[0], result_if.accepted);
				void'(verdict_q.pop_front());
			end else begin
				void'(verdict_q.pop_front());
			end
		end
	end

	// Watchdog: count cycles in which no handshake and no register write happens.
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) || cfg_we)
			stall_cycles <= 0;
		else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no progress for %0d cycles", $time, stall_cycles);
			$display("FAIL");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : stimulus
		item_word_t       w;
		int               r;
		int               items_done;
		int               n;
		int               s;
		int               i;
		int unsigned      len;
		bit               leave_open;
		bit               pressure_done;
		logic [FIELD_W-1:0] sv;

		item_if.valid       = 1'b0;
		item_if.func        = FUNC_RULE;
		item_if.rule_from   = '0;
		item_if.symbol      = '0;
		item_if.rule_to     = '0;
		item_if.last_symbol = 1'b0;
		items_done    = 0;
		pressure_done = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. The first word also waits out the clearing pass.
		for (r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_START) begin
				wait_drain();
				write_start(DIRECTED[r].start_val);
			end else begin
				w = '{DIRECTED[r].func, DIRECTED[r].rule_from, DIRECTED[r].symbol,
					DIRECTED[r].rule_to, DIRECTED[r].last_symbol};
				offer(w, DIRECTED[r].typed, DIRECTED[r].verdict);
			end
		end

		// Random phases: each picks a start, a small pool of nonterminals and a
		// window of three letters, adds rules over them, then feeds sentences made
		// of the same letters so that paths actually reach the end marker.
		while (items_done < RANDOM_ITEMS) begin
			wait_drain();
			case ($urandom_range(0, 9))
				0:       sv = NT_Z;
				1:       sv = FIELD_W'($urandom_range(NT, 31));
				2:       sv = NT_A;
				default: sv = FIELD_W'($urandom_range(0, NT - 1));
			endcase
			write_start(sv);
			nt_base  = $urandom_range(0, NT - 1);
			sym_base = $urandom_range(0, NS - 1);
			gapless  = ($urandom_range(0, 3) == 0);

			n = $urandom_range(4, 10);
			for (i = 0; i < n; i++) begin
				w = '{FUNC_RULE, pick_nt(), pick_sym(),
					($urandom_range(0, 3) == 0) ? END_MARK : pick_nt(),
					1'($urandom_range(0, 1))};
				offer(w, 1'b0, 1'b0);
				items_done++;
			end

			// Back-pressure: stall the receiver for a long stretch and keep offering
			// one-letter sentences, so the output register fills and input stalls.
			if (!pressure_done) begin
				pressure_done = 1'b1;
				hold_off_req  = 1'b1;
				gapless       = 1'b1;
				repeat (12) begin
					w = '{FUNC_SYMBOL, UNUSED, pick_sym(), UNUSED, 1'b1};
					offer(w, 1'b0, 1'b0);
					items_done++;
				end
			end

			n = $urandom_range(6, 16);
			leave_open = ($urandom_range(0, 5) == 0);
			for (s = 0; s < n; s++) begin
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++) begin
					case ($urandom_range(0, 19))
						0: begin
							// dropped rule: one field pushed out of range
							w = '{FUNC_RULE, FIELD_W'($urandom), FIELD_W'($urandom),
								FIELD_W'($urandom), 1'($urandom)};
							case ($urandom_range(0, 2))
								0:       w.rule_from = FIELD_W'($urandom_range(NT, 31));
								1:       w.symbol = FIELD_W'($urandom_range(NS, 31));
								default: w.rule_to = FIELD_W'($urandom_range(NT + 1, 31));
							endcase
							offer(w, 1'b0, 1'b0);
							items_done++;
						end
						1: begin
							w = '{FUNC_RULE, pick_nt(), pick_sym(), pick_nt(), 1'b0};
							offer(w, 1'b0, 1'b0);
							items_done++;
						end
						default: ;
					endcase
					// junk in the rule fields of a symbol word must be ignored
					w = '{FUNC_SYMBOL, FIELD_W'($urandom), pick_sym(), FIELD_W'($urandom),
						1'b0};
					if ($urandom_range(0, 19) == 0)
						w.symbol = FIELD_W'($urandom_range(NS, 31));
					w.last_symbol = (i == len - 1) && !(s == n - 1 && leave_open);
					offer(w, 1'b0, 1'b0);
					items_done++;
				end
			end
		end

		wait_drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/nwa_pkg.sv
hdl/nwa_if.sv
hdl/nwa_ram.sv
hdl/nwa_ctrl.sv
hdl/nwa_dp.sv
hdl/nfa_word_acceptor.sv
tb/tb_top.sv
